// File: rtl/slid_pkg.sv
`default_nettype none

package slid_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ELEMENT  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } t_out_word;

    // Commands from the controller to the entry datapath.
    typedef struct packed {
        logic             ins_en;
        logic [CNT_W-1:0] count;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/slid_datapath.sv
`default_nettype none

module slid_datapath (
    input  wire logic                        i_clk,
    input  wire slid_pkg::t_dp_cmd           i_cmd,
    input  wire logic signed [31:0]          i_value,
    output logic signed [31:0]               o_element
);
    import slid_pkg::*;

    logic signed [31:0] r_entries [CAPACITY];
    logic signed [31:0] n_entries [CAPACITY];
    logic [CAPACITY-1:0] lt;
    logic signed [31:0] r_element;

    // Each cell compares its own entry with the new value. Because the
    // row is sorted, the cells below the insert point form a prefix.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt[i] = (CNT_W'(i) < i_cmd.count) && (r_entries[i] < i_value);
        end
        n_entries[0] = lt[0] ? r_entries[0] : i_value;
        for (int i = 1; i < CAPACITY; i++) begin
            if (lt[i]) begin
                n_entries[i] = r_entries[i];
            end else if (lt[i-1]) begin
                n_entries[i] = i_value;
            end else begin
                n_entries[i] = r_entries[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
        if (i_cmd.rd_en) begin
            r_element <= r_entries[i_cmd.rd_idx];
        end else begin
            r_element <= '0;
        end
    end

    assign o_element = r_element;

endmodule

`default_nettype wire

// File: rtl/slid_ctrl.sv
`default_nettype none

module slid_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_opcode,
    output logic                   o_busy,
    output slid_pkg::t_dp_cmd      o_cmd,
    output logic                   o_strobe,
    output logic [1:0]             o_status,
    output logic                   o_last
);
    import slid_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_strobe, n_strobe;
    logic [1:0]       r_status, n_status;
    logic             r_last, n_last;
    logic             accept;
    logic             idx_last;

    assign accept   = i_start && (r_state == S_IDLE);
    assign idx_last = ({1'b0, r_idx} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_status = ST_INSERTED;
        n_last   = 1'b0;
        o_cmd    = '0;
        o_cmd.count  = r_count;
        o_cmd.rd_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    if (i_opcode == OP_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status     = ST_INSERTED;
                            o_cmd.ins_en = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // The dump words come out of the dump state.
                        n_strobe = 1'b0;
                        n_last   = 1'b0;
                        n_state  = S_DUMP;
                        n_idx    = '0;
                    end
                end
            end
            S_DUMP: begin
                o_cmd.rd_en = 1'b1;
                n_strobe    = 1'b1;
                n_status    = ST_ELEMENT;
                n_last      = idx_last;
                n_idx       = r_idx + IDX_W'(1);
                if (idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_INSERTED;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_busy   = (r_state == S_DUMP);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_last   = r_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !(i_opcode == OP_DUMP && r_count != '0)) |=> (r_strobe && r_last))
        else $error("accepted word without a single final result");

    a_dump_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> (r_strobe && r_status == ST_ELEMENT))
        else $error("dump cycle without an element word");

    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (r_state == S_IDLE))
        else $error("final word while still dumping");

    a_dump_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_count))
        else $error("entry count changed during dump");
`endif

endmodule

`default_nettype wire

// File: rtl/sorted_list_insert_and_dump.sv
`default_nettype none

// Channel   Handshake          Payload
// command   start / busy       i_item  (opcode, value)
// result    o_strobe           o_result (status, element, last)
//
// An insert is taken when start is high and busy is low; its status word appears in the next cycle
// and a new command may be taken in that same cycle.
// A dump of N stored values holds busy high and emits one element
// word per cycle, limited by the single read port on the entry row.
// A dump of an empty store answers with one word, like an insert.
// Reset is synchronous and empties the store; the receiver cannot stall.

module sorted_list_insert_and_dump (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire slid_pkg::t_in_word    i_item,
    output logic                       o_strobe,
    output slid_pkg::t_out_word        o_result
);
    import slid_pkg::*;

    t_dp_cmd            cmd;
    logic [1:0]         status;
    logic               last;
    logic signed [31:0] element;

    slid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .o_strobe (o_strobe),
        .o_status (status),
        .o_last   (last)
    );

    slid_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_value   (i_item.value),
        .o_element (element)
    );

    always_comb begin
        o_result.status  = status;
        o_result.element = element;
        o_result.last    = last;
    end

endmodule

`default_nettype wire
